FILE: design/pwbd_pkg.sv
package pwbd_pkg;

    // configuration register file
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_TARGET = 4'd0,
        REG_ONE_PERIOD  = 4'd1,
        REG_ZERO_PERIOD = 4'd2,
        REG_TOLERANCE   = 4'd3
    } t_cfg_reg;

    localparam logic [CFG_DATA_W-1:0] RST_HIGH_TARGET = 16'd50;
    localparam logic [CFG_DATA_W-1:0] RST_ONE_PERIOD  = 16'd150;
    localparam logic [CFG_DATA_W-1:0] RST_ZERO_PERIOD = 16'd100;
    localparam logic [CFG_DATA_W-1:0] RST_TOLERANCE   = 16'd10;

    // widest measured value: a period sum of two counters up to 32 bits wide
    localparam int MEAS_W = 33;

    localparam int BYTE_W = 8;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] high_target;
        logic [CFG_DATA_W-1:0] one_period;
        logic [CFG_DATA_W-1:0] zero_period;
        logic [CFG_DATA_W-1:0] tolerance;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              noise_flag;
    } t_result;

    // absolute difference against a target, inclusive tolerance
    function automatic logic within_tol(input logic [MEAS_W-1:0] measured,
                                        input logic [CFG_DATA_W-1:0] target,
                                        input logic [CFG_DATA_W-1:0] tol);
        logic [MEAS_W-1:0] t_ext;
        logic [MEAS_W-1:0] diff;
        t_ext = MEAS_W'(target);
        diff = (measured >= t_ext) ? (measured - t_ext) : (t_ext - measured);
        return diff <= MEAS_W'(tol);
    endfunction

endpackage

FILE: design/pwbd_if.sv
interface pwbd_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink   (input valid, input line_level, output ready);
endinterface

interface pwbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       noise_flag;

    modport source (output valid, output data_byte, output noise_flag, input ready);
    modport sink   (input valid, input data_byte, input noise_flag, output ready);
endinterface

interface pwbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/pwbd_cfg_regs.sv
module pwbd_cfg_regs
    import pwbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the write beat, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                REG_HIGH_TARGET: n_cfg.high_target = i_data;
                REG_ONE_PERIOD:  n_cfg.one_period  = i_data;
                REG_ZERO_PERIOD: n_cfg.zero_period = i_data;
                REG_TOLERANCE:   n_cfg.tolerance   = i_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_target <= RST_HIGH_TARGET;
            r_cfg.one_period  <= RST_ONE_PERIOD;
            r_cfg.zero_period <= RST_ZERO_PERIOD;
            r_cfg.tolerance   <= RST_TOLERANCE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/pwbd_core.sv
module pwbd_core
    import pwbd_pkg::*;
#(
    parameter int COUNT_WIDTH   = 16,
    parameter int BITS_PER_WORD = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_line,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int BP_W = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    t_phase                   r_phase, n_phase;
    logic [BP_W-1:0]          r_bit_pos, n_bit_pos;
    logic [COUNT_WIDTH-1:0]   r_high_cnt, n_high_cnt;
    logic [COUNT_WIDTH-1:0]   r_low_cnt, n_low_cnt;
    logic [BITS_PER_WORD-1:0] r_shift, n_shift;

    logic [COUNT_WIDTH:0]     period;
    logic                     high_ok;
    logic                     is_one;
    logic                     is_zero;
    logic [BITS_PER_WORD-1:0] shift_set;
    logic [BITS_PER_WORD+BYTE_W-1:0] word_ext;

    // timing checks on the current counts
    assign period    = {1'b0, r_high_cnt} + {1'b0, r_low_cnt};
    assign high_ok   = within_tol(MEAS_W'(r_high_cnt), i_cfg.high_target, i_cfg.tolerance);
    assign is_one    = within_tol(MEAS_W'(period), i_cfg.one_period, i_cfg.tolerance);
    assign is_zero   = within_tol(MEAS_W'(period), i_cfg.zero_period, i_cfg.tolerance);
    assign shift_set = r_shift | (BITS_PER_WORD'(is_one) << r_bit_pos);
    assign word_ext  = {{BYTE_W{1'b0}}, shift_set};

    // phase sequencer for one line sample
    always_comb begin
        n_phase    = r_phase;
        n_bit_pos  = r_bit_pos;
        n_high_cnt = r_high_cnt;
        n_low_cnt  = r_low_cnt;
        n_shift    = r_shift;
        o_result   = '0;
        case (r_phase)
            PH_HIGH: begin
                if (i_line) begin
                    if (r_high_cnt != {COUNT_WIDTH{1'b1}}) begin
                        n_high_cnt = r_high_cnt + 1'b1;
                    end
                end else if (!high_ok) begin
                    n_phase             = PH_WAIT;
                    n_bit_pos           = '0;
                    n_shift             = '0;
                    o_result.valid      = 1'b1;
                    o_result.noise_flag = 1'b1;
                end else begin
                    n_phase   = PH_LOW;
                    n_low_cnt = COUNT_WIDTH'(1);
                end
            end
            PH_LOW: begin
                if (!i_line) begin
                    if (r_low_cnt != {COUNT_WIDTH{1'b1}}) begin
                        n_low_cnt = r_low_cnt + 1'b1;
                    end
                end else begin
                    // every outcome here but a middle bit restarts the word
                    n_phase    = PH_HIGH;
                    n_high_cnt = COUNT_WIDTH'(1);
                    n_low_cnt  = '0;
                    if (!is_one && !is_zero) begin
                        n_bit_pos           = '0;
                        n_shift             = '0;
                        o_result.valid      = 1'b1;
                        o_result.noise_flag = 1'b1;
                    end else if (r_bit_pos == BP_W'(BITS_PER_WORD - 1)) begin
                        n_bit_pos          = '0;
                        n_shift            = '0;
                        o_result.valid     = 1'b1;
                        o_result.data_byte = word_ext[BYTE_W-1:0];
                    end else begin
                        n_bit_pos = r_bit_pos + 1'b1;
                        n_shift   = shift_set;
                    end
                end
            end
            default: begin
                // waiting for the line to rise, also the unused codes
                if (i_line) begin
                    n_phase    = PH_HIGH;
                    n_bit_pos  = '0;
                    n_shift    = '0;
                    n_high_cnt = COUNT_WIDTH'(1);
                    n_low_cnt  = '0;
                end else begin
                    n_phase = PH_WAIT;
                end
            end
        endcase
        if (!i_accept) begin
            o_result.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_bit_pos  <= '0;
            r_high_cnt <= '0;
            r_low_cnt  <= '0;
            r_shift    <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_bit_pos  <= n_bit_pos;
            r_high_cnt <= n_high_cnt;
            r_low_cnt  <= n_low_cnt;
            r_shift    <= n_shift;
        end
    end

endmodule

FILE: design/pwbd_out_stage.sv
module pwbd_out_stage
    import pwbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_result           i_result,
    input  logic              i_take,
    output logic              o_room,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_noise_flag
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_data_byte;
    logic              r_noise_flag;

    // the slot frees in the same cycle its beat is taken
    assign o_room = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_result.valid) begin
            r_data_byte  <= i_result.data_byte;
            r_noise_flag <= i_result.noise_flag;
        end
    end

    assign o_valid      = r_valid;
    assign o_data_byte  = r_data_byte;
    assign o_noise_flag = r_noise_flag;

endmodule

FILE: design/pulse_width_byte_decoder.sv
// channel   dir  beat payload            notes
// i_line    in   line_level              one line sample per beat
// o_result  out  data_byte, noise_flag   zero or one beat per sample
// i_cfg     in   index, data             register write, always ready
//
// one sample is taken per cycle while the result slot has room; the phase
// sequencer and the timing checks sit between the state registers and a
// single result register; the result register is the only stage, so a held
// result stalls the input only while the sink keeps ready low
// synchronous active-low reset restores default timing and waits for high
module pulse_width_byte_decoder
    import pwbd_pkg::*;
#(
    parameter int COUNT_WIDTH   = 16,
    parameter int BITS_PER_WORD = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pwbd_in_if.sink     i_line,
    pwbd_out_if.source  o_result,
    pwbd_cfg_if.sink    i_cfg
);

    t_cfg    cfg;
    t_result core_result;
    logic    room;
    logic    in_accept;

    // configuration writes are taken every cycle
    assign i_cfg.ready = 1'b1;

    pwbd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // a sample is taken whenever the result slot can hold its outcome
    assign i_line.ready = room;
    assign in_accept    = i_line.valid && room;

    pwbd_core #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .BITS_PER_WORD (BITS_PER_WORD)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_line   (i_line.line_level),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    pwbd_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (core_result),
        .i_take       (o_result.ready),
        .o_room       (room),
        .o_valid      (o_result.valid),
        .o_data_byte  (o_result.data_byte),
        .o_noise_flag (o_result.noise_flag)
    );

endmodule

FILE: dv/pwbd_checker.sv
`timescale 1ns / 1ps

// watches the line, result and register channels, predicts every result
// beat from the accepted line samples and compares in order
module pwbd_checker
    import pwbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pwbd_in_if   i_line,
    pwbd_out_if  i_result,
    pwbd_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_bytes,
    output int   o_noise,
    output int   o_samples
);

    localparam int CNT_W     = 16;
    localparam int WORD_BITS = 8;

    typedef enum logic [1:0] {
        LINE_IDLE,
        LINE_MARK,
        LINE_SPACE
    } t_line_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       noise_flag;
    } t_rx_word;

    // predictor state and its copy of the timing registers
    t_cfg             timing;
    t_line_phase      phase;
    logic [2:0]       bit_idx;
    logic [CNT_W-1:0] mark_cnt;
    logic [CNT_W-1:0] space_cnt;
    logic [7:0]       rx_shift;

    t_rx_word expected_words[$];
    t_rx_word got;
    t_rx_word want;

    int fail_count   = 0;
    int byte_count   = 0;
    int noise_count  = 0;
    int sample_count = 0;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // inclusive absolute-difference window, one bit wider than the counters
    function automatic logic near(input logic [CNT_W:0] meas,
                                  input logic [CNT_W-1:0] target,
                                  input logic [CNT_W-1:0] tol);
        logic [CNT_W:0] diff;
        diff = (meas >= {1'b0, target}) ? meas - {1'b0, target}
                                        : {1'b0, target} - meas;
        return diff <= {1'b0, tol};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // the high sample that opens a word counts as its first mark tick
    task automatic start_word();
        phase     = LINE_MARK;
        bit_idx   = '0;
        rx_shift  = '0;
        mark_cnt  = CNT_W'(1);
        space_cnt = '0;
    endtask

    // advance the decoder by one line sample, queue any result it causes
    task automatic decode_sample(input logic lvl);
        logic [CNT_W:0] period;
        logic           is_one;
        logic           is_zero;
        case (phase)
            LINE_MARK: begin
                if (lvl) begin
                    mark_cnt = sat_inc(mark_cnt);
                end else if (!near({1'b0, mark_cnt}, timing.high_target,
                                   timing.tolerance)) begin
                    phase    = LINE_IDLE;
                    bit_idx  = '0;
                    rx_shift = '0;
                    expected_words.push_back(t_rx_word'{data_byte: 8'h00,
                                                        noise_flag: 1'b1});
                end else begin
                    phase     = LINE_SPACE;
                    space_cnt = CNT_W'(1);
                end
            end
            LINE_SPACE: begin
                if (!lvl) begin
                    space_cnt = sat_inc(space_cnt);
                end else begin
                    period  = {1'b0, mark_cnt} + {1'b0, space_cnt};
                    is_one  = near(period, timing.one_period, timing.tolerance);
                    is_zero = near(period, timing.zero_period, timing.tolerance);
                    if (!is_one && !is_zero) begin
                        start_word();
                        expected_words.push_back(t_rx_word'{data_byte: 8'h00,
                                                            noise_flag: 1'b1});
                    end else begin
                        if (is_one) rx_shift[bit_idx] = 1'b1;
                        if (bit_idx == 3'(WORD_BITS - 1)) begin
                            expected_words.push_back(t_rx_word'{data_byte: rx_shift,
                                                                noise_flag: 1'b0});
                            start_word();
                        end else begin
                            bit_idx   = bit_idx + 1'b1;
                            phase     = LINE_MARK;
                            mark_cnt  = CNT_W'(1);
                            space_cnt = '0;
                        end
                    end
                end
            end
            // idle, and the unused phase code
            default: begin
                if (lvl) start_word();
                else phase = LINE_IDLE;
            end
        endcase
    endtask

    // results are registered, so a result beat never belongs to a sample
    // taken at the same edge: compare first, then predict
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timing.high_target = RST_HIGH_TARGET;
            timing.one_period  = RST_ONE_PERIOD;
            timing.zero_period = RST_ZERO_PERIOD;
            timing.tolerance   = RST_TOLERANCE;
            phase     = LINE_IDLE;
            bit_idx   = '0;
            mark_cnt  = '0;
            space_cnt = '0;
            rx_shift  = '0;
            expected_words.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.data_byte  = i_result.data_byte;
                got.noise_flag = i_result.noise_flag;
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result beat byte %02h noise %0b with none expected",
                                              got.data_byte, got.noise_flag));
                end else begin
                    want = expected_words.pop_front();
                    if (got.data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte %02h, expected %02h",
                                                  got.data_byte, want.data_byte));
                    if (got.noise_flag !== want.noise_flag)
                        report_mismatch($sformatf("noise_flag %0b, expected %0b",
                                                  got.noise_flag, want.noise_flag));
                    if (want.noise_flag) noise_count++;
                    else byte_count++;
                end
            end

            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_HIGH_TARGET: timing.high_target = i_cfg.data;
                    REG_ONE_PERIOD:  timing.one_period  = i_cfg.data;
                    REG_ZERO_PERIOD: timing.zero_period = i_cfg.data;
                    REG_TOLERANCE:   timing.tolerance   = i_cfg.data;
                    default: ;
                endcase
            end

            if (i_line.valid && i_line.ready) begin
                decode_sample(i_line.line_level);
                sample_count++;
            end
        end

        o_pending    <= expected_words.size();
        o_fail_count <= fail_count;
        o_bytes      <= byte_count;
        o_noise      <= noise_count;
        o_samples    <= sample_count;
    end

endmodule

FILE: dv/pulse_width_byte_decoder_tb.sv
`timescale 1ns / 1ps

module pulse_width_byte_decoder_tb;
    import pwbd_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {
        BREAK_NONE,
        BREAK_MARK,
        BREAK_PERIOD
    } t_pulse_fault;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pwbd_in_if  line_if ();
    pwbd_out_if res_if ();
    pwbd_cfg_if cfg_if ();

    int fail_count;
    int pending;
    int byte_count;
    int noise_count;
    int sample_count;

    int cycle_cnt     = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int n_sent        = 0;
    int n_setups      = 0;
    int hi_t;
    int one_t;
    int zero_t;
    int tol_t;

    int idle_mix_src[4] = '{0, 82, 0, 27};
    int idle_mix_snk[4] = '{0, 0, 82, 27};

    pulse_width_byte_decoder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_line   (line_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    pwbd_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line       (line_if),
        .i_result     (res_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_bytes      (byte_count),
        .o_noise      (noise_count),
        .o_samples    (sample_count)
    );

    always #1 i_clk = ~i_clk;

    // result sink stalls
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("FAIL pulse_width_byte_decoder");
            $finish;
        end
    end

    function automatic int jitter(input int target, input int spread);
        return target - spread + int'($urandom_range(0, 2 * spread));
    endfunction

    // one line beat, with random sender gaps ahead of it
    task automatic send_sample(input logic lvl);
        while ($urandom_range(99) < src_idle_pct) begin
            line_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        line_if.valid      <= 1'b1;
        line_if.line_level <= lvl;
        do @(posedge i_clk); while (!line_if.ready);
        n_sent++;
    endtask

    task automatic send_pulse(input int mark, input int space);
        repeat (mark) send_sample(1'b1);
        repeat (space) send_sample(1'b0);
    endtask

    // eight pulses lsb first around the current targets, one of them
    // optionally pushed outside its window
    task automatic send_word(input logic [7:0] val, input int bad_bit,
                             input t_pulse_fault fault);
        int mark;
        int period;
        for (int i = 0; i < 8; i++) begin
            mark = jitter(hi_t, tol_t);
            if (mark < 1) mark = 1;
            period = jitter(val[i] ? one_t : zero_t, tol_t);
            if (i == bad_bit && fault == BREAK_MARK)
                mark = hi_t + tol_t + 1 + int'($urandom_range(0, 2));
            if (i == bad_bit && fault == BREAK_PERIOD)
                period = ((one_t > zero_t) ? one_t : zero_t) + tol_t + 1
                         + int'($urandom_range(0, 3));
            send_pulse(mark, (period - mark < 1) ? 1 : period - mark);
        end
    endtask

    // write all four timing registers, optionally one unmapped index too
    task automatic program_timing(input int hi, input int one, input int zero,
                                  input int tol, input bit junk);
        t_cfg_reg    regs[4];
        logic [15:0] vals[4];
        regs[0] = REG_HIGH_TARGET;
        regs[1] = REG_ONE_PERIOD;
        regs[2] = REG_ZERO_PERIOD;
        regs[3] = REG_TOLERANCE;
        vals[0] = 16'(hi);
        vals[1] = 16'(one);
        vals[2] = 16'(zero);
        vals[3] = 16'(tol);
        for (int r = 0; r < 4 + int'(junk); r++) begin
            cfg_if.valid <= 1'b1;
            if (r < 4) begin
                cfg_if.index <= regs[r];
                cfg_if.data  <= vals[r];
            end else begin
                cfg_if.index <= 4'(REG_TOLERANCE) + 4'($urandom_range(1, 12));
                cfg_if.data  <= 16'($urandom);
            end
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        hi_t   = hi;
        one_t  = one;
        zero_t = zero;
        tol_t  = tol;
        n_setups++;
    endtask

    // stop the line and let every predicted result arrive
    task automatic wait_idle(input int settle);
        line_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin
        int r;
        int hi;

        i_rst_n            <= 1'b0;
        line_if.valid      <= 1'b0;
        line_if.line_level <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= REG_HIGH_TARGET;
        cfg_if.data        <= '0;
        hi_t   = int'(RST_HIGH_TARGET);
        one_t  = int'(RST_ONE_PERIOD);
        zero_t = int'(RST_ZERO_PERIOD);
        tol_t  = int'(RST_TOLERANCE);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing: one zero bit, then a mark far too short
        send_pulse(0, 2);
        send_pulse(50, 50);
        send_pulse(3, 1);
        send_sample(1'b1);
        wait_idle(SETTLE_CYCLES);

        // directed: high window 1..3, zero period 3..5, one period 5..7
        program_timing(2, 6, 4, 1, 1'b0);
        send_pulse(0, 3);
        send_pulse(3, 2);   // mark at window edge, period in both windows
        send_pulse(1, 2);   // zero at lower period edge
        send_pulse(2, 5);   // one at upper period edge
        send_pulse(2, 2);
        send_pulse(2, 4);
        send_pulse(2, 3);
        send_pulse(2, 2);
        send_pulse(2, 2);   // word completes on the next high
        send_pulse(4, 2);   // mark too long, back to idle
        send_pulse(2, 7);   // period outside both windows
        send_pulse(2, 1);   // restarted word continues
        send_pulse(3, 4);
        send_sample(1'b1);
        wait_idle(SETTLE_CYCLES);

        // zero high target, every mark fails
        program_timing(0, 65535, 0, 0, 1'b1);
        send_pulse(1, 1);
        send_sample(1'b1);
        wait_idle(SETTLE_CYCLES);

        // widest tolerance accepts every pulse sent here as a one
        program_timing(65535, 0, 65535, 65535, 1'b0);
        repeat (9) send_pulse(1, 1);
        send_sample(1'b1);
        wait_idle(SETTLE_CYCLES);

        // random words, mostly clean, under each idle and stall mix
        for (int m = 0; m < 4; m++) begin
            src_idle_pct  = idle_mix_src[m];
            snk_stall_pct = idle_mix_snk[m];
            for (int s = 0; s < 2; s++) begin
                hi = $urandom_range(1, 6);
                program_timing(hi, hi + int'($urandom_range(1, 10)),
                               hi + int'($urandom_range(1, 10)),
                               $urandom_range(0, 2), 1'($urandom_range(0, 1)));
                n_sent = 0;
                send_pulse(0, $urandom_range(1, 4));
                while (n_sent < 80) begin
                    r = $urandom_range(99);
                    if (r < 72)
                        send_word(8'($urandom), -1, BREAK_NONE);
                    else if (r < 82)
                        send_word(8'($urandom), $urandom_range(0, 7), BREAK_MARK);
                    else if (r < 92)
                        send_word(8'($urandom), $urandom_range(0, 7), BREAK_PERIOD);
                    else
                        repeat ($urandom_range(1, 16)) send_sample(1'($urandom_range(0, 1)));
                end
                send_sample(1'b1);
                wait_idle(SETTLE_CYCLES);
            end
        end

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        wait_idle(16);

        $display("covered %0d line samples over %0d timing setups and four idle/stall mixes",
                 sample_count, n_setups);
        $display("compared %0d decoded bytes and %0d noise flags, %0d mismatches",
                 byte_count, noise_count, fail_count);
        if (fail_count == 0)
            $display("PASS pulse_width_byte_decoder");
        else
            $display("FAIL pulse_width_byte_decoder");
        $finish;
    end

endmodule
